// File: hw/rtl/tgi_pkg.sv
// tgi_pkg: shared types, codes and blend arithmetic of the trilinear grid interpolator
package tgi_pkg;

	localparam int GRID_AW = 15;
	localparam int Q_DEPTH = 4;
	localparam int Q_AW = 2;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_LOOKUP = 1'b1;

	localparam logic [2:0] CFG_ORIGIN_X = 3'd0;
	localparam logic [2:0] CFG_ORIGIN_Y = 3'd1;
	localparam logic [2:0] CFG_ORIGIN_Z = 3'd2;
	localparam logic [2:0] CFG_RECIP_X = 3'd3;
	localparam logic [2:0] CFG_RECIP_Y = 3'd4;
	localparam logic [2:0] CFG_RECIP_Z = 3'd5;

	localparam logic [31:0] RECIP_RESET = 32'h0001_0000;
	localparam logic [16:0] FRAC_ONE = 17'h1_0000;

	typedef struct packed {
		logic func;
		logic [GRID_AW-1:0] point_index;
		logic signed [31:0] point_value;
		logic signed [31:0] coord_x;
		logic signed [31:0] coord_y;
		logic signed [31:0] coord_z;
	} tgi_item_t;

	typedef struct packed {
		logic signed [31:0] interp_value;
		logic in_range;
	} tgi_result_t;

	typedef struct packed {
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic signed [31:0] origin_z;
		logic [31:0] recip_x;
		logic [31:0] recip_y;
		logic [31:0] recip_z;
	} tgi_cfg_t;

	// one classified job between front and back
	typedef struct packed {
		logic is_lookup;
		logic in_range;
		logic [GRID_AW-1:0] wr_index;
		logic signed [31:0] wr_value;
		logic [7:0][GRID_AW-1:0] addr;
		logic [16:0] t;
		logic [16:0] u;
		logic [16:0] w;
	} tgi_job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} tgi_qstat_t;

	// first half of a blend: (b - a) * t
	function automatic logic signed [50:0] lerp_mul(logic signed [31:0] a,
			logic signed [31:0] b, logic [16:0] t);
		logic signed [32:0] diff;
		diff = 33'(b) - 33'(a);
		return diff * $signed({1'b0, t});
	endfunction

	// second half: a + prod / 65536 rounded half up, saturated
	function automatic logic signed [31:0] lerp_fin(logic signed [31:0] a,
			logic signed [50:0] prod);
		logic signed [51:0] v;
		logic signed [35:0] r;
		v = (52'(a) <<< 16) + 52'(prod) + 52'sd32768;
		r = v[51:16];
		if (r > 36'sd2147483647) begin
			return 32'sh7fff_ffff;
		end else if (r < -36'sd2147483648) begin
			return 32'sh8000_0000;
		end
		return r[31:0];
	endfunction

endpackage

// File: hw/rtl/tgi_front.sv
// tgi_front: accepts items, locates the cell per axis and forms corner addresses
module tgi_front #(
	parameter int CELLS_X = 31,
	parameter int CELLS_Y = 31,
	parameter int CELLS_Z = 31
) (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_ready,
	input  tgi_pkg::tgi_item_t item,
	input  tgi_pkg::tgi_cfg_t cfg,
	input  tgi_pkg::tgi_qstat_t qstat,
	output logic push,
	output tgi_pkg::tgi_job_t job
);

	localparam int unsigned ROWX = CELLS_X + 1;
	localparam int unsigned PLANE = (CELLS_X + 1) * (CELLS_Y + 1);
	localparam logic [tgi_pkg::GRID_AW-1:0] ROWX_A = tgi_pkg::GRID_AW'(ROWX);
	localparam logic [tgi_pkg::GRID_AW-1:0] PLANE_A = tgi_pkg::GRID_AW'(PLANE);
	localparam logic [31:0] CELLS_V [3] = '{32'(CELLS_X), 32'(CELLS_Y), 32'(CELLS_Z)};

	logic advance;
	logic signed [31:0] coord [3];
	logic signed [31:0] origin [3];
	logic [31:0] recip [3];

	logic v_s1, v_s2, v_s3;
	logic func_s1, func_s2;
	logic bad_s1, bad_s2;
	logic [tgi_pkg::GRID_AW-1:0] idx_s1, idx_s2;
	logic signed [31:0] val_s1, val_s2;
	logic [31:0] dm_s1 [3];
	logic [63:0] p_s2 [3];
	logic signed [32:0] d [3];
	logic neg [3];

	logic out_a [3];
	logic [7:0] cell_no [3];
	logic [16:0] frac [3];
	logic [tgi_pkg::GRID_AW-1:0] base;
	tgi_pkg::tgi_job_t job_next, job_s3;

	assign coord[0] = item.coord_x;
	assign coord[1] = item.coord_y;
	assign coord[2] = item.coord_z;
	assign origin[0] = cfg.origin_x;
	assign origin[1] = cfg.origin_y;
	assign origin[2] = cfg.origin_z;
	assign recip[0] = cfg.recip_x;
	assign recip[1] = cfg.recip_y;
	assign recip[2] = cfg.recip_z;

	assign advance = !(v_s3 && qstat.full);
	assign item_ready = advance;
	assign push = v_s3 && !qstat.full;
	assign job = job_s3;

	for (genvar a = 0; a < 3; a++) begin : g_axis
		assign d[a] = 33'(coord[a]) - 33'(origin[a]);
		assign neg[a] = d[a][32];

		always_comb begin
			logic [31:0] hi;
			logic top;
			hi = p_s2[a][63:32];
			top = (hi == CELLS_V[a]);
			out_a[a] = (hi > CELLS_V[a]) || (top && (p_s2[a][31:0] != 32'd0));
			cell_no[a] = top ? 8'(CELLS_V[a] - 32'd1) : hi[7:0];
			frac[a] = top ? tgi_pkg::FRAC_ONE : {1'b0, p_s2[a][31:16]};
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				dm_s1[a] <= d[a][31:0];
				p_s2[a] <= 64'(dm_s1[a]) * 64'(recip[a]);
			end
		end
	end

	assign base = tgi_pkg::GRID_AW'(32'(cell_no[0]) + 32'(ROWX) * 32'(cell_no[1])
		+ 32'(PLANE) * 32'(cell_no[2]));

	always_comb begin
		job_next.is_lookup = (func_s2 == tgi_pkg::FUNC_LOOKUP);
		job_next.in_range = !bad_s2 && !out_a[0] && !out_a[1] && !out_a[2];
		job_next.wr_index = idx_s2;
		job_next.wr_value = val_s2;
		for (int n = 0; n < 8; n++) begin
			job_next.addr[n] = base + (n[0] ? tgi_pkg::GRID_AW'(1) : '0)
				+ (n[1] ? ROWX_A : '0) + (n[2] ? PLANE_A : '0);
		end
		job_next.t = frac[0];
		job_next.u = frac[1];
		job_next.w = frac[2];
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			func_s1 <= item.func;
			idx_s1 <= item.point_index;
			val_s1 <= item.point_value;
			bad_s1 <= neg[0] || neg[1] || neg[2] || (recip[0] == 32'd0)
				|| (recip[1] == 32'd0) || (recip[2] == 32'd0);
			func_s2 <= func_s1;
			idx_s2 <= idx_s1;
			val_s2 <= val_s1;
			bad_s2 <= bad_s1;
			job_s3 <= job_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (advance) begin
			v_s1 <= item_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

endmodule

// File: hw/rtl/tgi_queue.sv
// tgi_queue: short job queue between front and back
module tgi_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  tgi_pkg::tgi_job_t push_job,
	input  logic pop,
	output tgi_pkg::tgi_job_t head,
	output tgi_pkg::tgi_qstat_t qstat
);

	tgi_pkg::tgi_job_t entries_q [tgi_pkg::Q_DEPTH];
	logic [tgi_pkg::Q_AW-1:0] wp_q, rp_q;
	logic [tgi_pkg::Q_AW:0] cnt_q;

	assign head = entries_q[rp_q];
	assign qstat.full = (cnt_q == (tgi_pkg::Q_AW+1)'(tgi_pkg::Q_DEPTH));
	assign qstat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wp_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: hw/rtl/tgi_back.sv
// tgi_back: grid storage in eight read copies and the three blend levels
module tgi_back (
	input  logic clk,
	input  logic arst_n,
	input  tgi_pkg::tgi_job_t head,
	input  tgi_pkg::tgi_qstat_t qstat,
	output logic pop,
	output logic result_valid,
	input  logic result_ready,
	output tgi_pkg::tgi_result_t result
);

	localparam int DEPTH = 2 ** tgi_pkg::GRID_AW;

	logic advance;
	logic v_b1, v_b2, v_b3, v_b4, v_b5, v_b6, v_b7;
	logic ir_b1, ir_b2, ir_b3, ir_b4, ir_b5, ir_b6;
	logic [16:0] t_b1;
	logic [16:0] u_b1, u_b2, u_b3;
	logic [16:0] w_b1, w_b2, w_b3, w_b4, w_b5;
	logic signed [31:0] rd_b1 [8];
	logic signed [50:0] px_b2 [4];
	logic signed [31:0] ax_b2 [4];
	logic signed [31:0] cx_b3 [4];
	logic signed [50:0] py_b4 [2];
	logic signed [31:0] ay_b4 [2];
	logic signed [31:0] cy_b5 [2];
	logic signed [50:0] pz_b6;
	logic signed [31:0] az_b6;
	tgi_pkg::tgi_result_t res_b7;

	assign advance = !(v_b7 && !result_ready);
	assign pop = advance && !qstat.empty;
	assign result_valid = v_b7;
	assign result = res_b7;

	// every copy takes every write, each serves one corner
	for (genvar n = 0; n < 8; n++) begin : g_copy
		logic signed [31:0] mem [DEPTH];
		always_ff @(posedge clk) begin
			if (pop) begin
				if (!head.is_lookup) begin
					mem[head.wr_index] <= head.wr_value;
				end else begin
					rd_b1[n] <= mem[head.addr[n]];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ir_b1 <= head.in_range;
			t_b1 <= head.t;
			u_b1 <= head.u;
			w_b1 <= head.w;
			for (int p = 0; p < 4; p++) begin
				px_b2[p] <= tgi_pkg::lerp_mul(rd_b1[2*p], rd_b1[2*p+1], t_b1);
				ax_b2[p] <= rd_b1[2*p];
				cx_b3[p] <= tgi_pkg::lerp_fin(ax_b2[p], px_b2[p]);
			end
			ir_b2 <= ir_b1;
			u_b2 <= u_b1;
			w_b2 <= w_b1;
			ir_b3 <= ir_b2;
			u_b3 <= u_b2;
			w_b3 <= w_b2;
			for (int q = 0; q < 2; q++) begin
				py_b4[q] <= tgi_pkg::lerp_mul(cx_b3[2*q], cx_b3[2*q+1], u_b3);
				ay_b4[q] <= cx_b3[2*q];
				cy_b5[q] <= tgi_pkg::lerp_fin(ay_b4[q], py_b4[q]);
			end
			ir_b4 <= ir_b3;
			w_b4 <= w_b3;
			ir_b5 <= ir_b4;
			w_b5 <= w_b4;
			pz_b6 <= tgi_pkg::lerp_mul(cy_b5[0], cy_b5[1], w_b5);
			az_b6 <= cy_b5[0];
			ir_b6 <= ir_b5;
			res_b7.interp_value <= ir_b6 ? tgi_pkg::lerp_fin(az_b6, pz_b6) : 32'sd0;
			res_b7.in_range <= ir_b6;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1 <= 1'b0;
			v_b2 <= 1'b0;
			v_b3 <= 1'b0;
			v_b4 <= 1'b0;
			v_b5 <= 1'b0;
			v_b6 <= 1'b0;
			v_b7 <= 1'b0;
		end else if (advance) begin
			v_b1 <= pop && head.is_lookup;
			v_b2 <= v_b1;
			v_b3 <= v_b2;
			v_b4 <= v_b3;
			v_b5 <= v_b4;
			v_b6 <= v_b5;
			v_b7 <= v_b6;
		end
	end

endmodule

// File: hw/rtl/trilinear_grid_interpolator.sv
// trilinear_grid_interpolator: top level with configuration registers and checks
// Trilinear interpolation over a uniform grid of (CELLS_X+1)(CELLS_Y+1)(CELLS_Z+1)
// Q16.16 samples stored by linear index, x fastest. An item with func set to write stores
// one sample and gives no result; a lookup item gives one result holding the blended
// value, or zero with in_range low when the point lies outside the grid or a reciprocal
// step is zero. Samples must be written before they are read. The block takes one item
// every cycle while item_ready is high (it drops while a finished job waits on a full job
// queue); a lookup passes three front stages for locate, the job queue, a memory read
// and six blend stages. Throughput is set by the grid store, kept as eight copies so that
// all eight corners are read in the same cycle through one port each.
// Configuration is written through the cfg channel, which is always ready.
module trilinear_grid_interpolator #(
	parameter int CELLS_X = 31,
	parameter int CELLS_Y = 31,
	parameter int CELLS_Z = 31
) (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_ready,
	input  tgi_pkg::tgi_item_t item,
	output logic result_valid,
	input  logic result_ready,
	output tgi_pkg::tgi_result_t result,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [31:0] cfg_data
);

	tgi_pkg::tgi_cfg_t cfg_q;
	tgi_pkg::tgi_qstat_t qstat;
	tgi_pkg::tgi_job_t push_job, head;
	logic push, pop;

	// config writes land at once
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x <= '0;
			cfg_q.origin_y <= '0;
			cfg_q.origin_z <= '0;
			cfg_q.recip_x <= tgi_pkg::RECIP_RESET;
			cfg_q.recip_y <= tgi_pkg::RECIP_RESET;
			cfg_q.recip_z <= tgi_pkg::RECIP_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				tgi_pkg::CFG_ORIGIN_X: cfg_q.origin_x <= cfg_data;
				tgi_pkg::CFG_ORIGIN_Y: cfg_q.origin_y <= cfg_data;
				tgi_pkg::CFG_ORIGIN_Z: cfg_q.origin_z <= cfg_data;
				tgi_pkg::CFG_RECIP_X: cfg_q.recip_x <= cfg_data;
				tgi_pkg::CFG_RECIP_Y: cfg_q.recip_y <= cfg_data;
				tgi_pkg::CFG_RECIP_Z: cfg_q.recip_z <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// front: locate and classify
	tgi_front #(
		.CELLS_X(CELLS_X),
		.CELLS_Y(CELLS_Y),
		.CELLS_Z(CELLS_Z)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.cfg(cfg_q),
		.qstat(qstat),
		.push(push),
		.job(push_job)
	);

	// decouples the front from output stalls
	tgi_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_job(push_job),
		.pop(pop),
		.head(head),
		.qstat(qstat)
	);

	// back: grid store and blend
	tgi_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.qstat(qstat),
		.pop(pop),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	// front never pushes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && qstat.full))
		else $error("job pushed into full queue");

	// back never pops an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && qstat.empty))
		else $error("job popped from empty queue");

	// out-of-range results carry zero
	a_zero_out: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.in_range |-> result.interp_value == 32'sd0)
		else $error("out-of-range result is not zero");

endmodule

// File: test/testbench.sv
// testbench: self-checking testbench of the trilinear grid interpolator
`timescale 1ns / 100ps

module testbench;
	import tgi_pkg::*;

	localparam int CELLS = 31;
	localparam int ROW_PTS = CELLS + 1;
	localparam int PLANE_PTS = ROW_PTS * ROW_PTS;
	localparam int GRID_PTS = 32768;
	localparam int DRAIN_CYCLES = 24;
	localparam int HOLD_CYCLES = 400;
	localparam int CYCLE_LIMIT = 600000;
	localparam int ITEMS_PER_PHASE = 285;
	localparam int ITEM_W = $bits(tgi_item_t);

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	// one row of the directed table
	typedef struct {
		row_kind_t kind;
		tgi_item_t item;
		logic [2:0] index;
		logic [31:0] data;
		bit typed;
		tgi_result_t res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid, item_ready, result_valid, result_ready;
	logic cfg_valid, cfg_ready;
	tgi_item_t item;
	tgi_result_t result;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;

	// predictor state: register copies and the grid as far as it has been written
	logic signed [31:0] origin_r [3];
	logic [31:0] recip_r [3];
	logic signed [31:0] grid_mem [GRID_PTS];
	bit written [GRID_PTS];

	tgi_result_t pending_results [$];
	int errors = 0;
	int cycles = 0;
	int tx_pct = 0;
	int rx_pct = 0;
	int hold_reqs = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int items_sent = 0;
	stim_row_t rows [$];

	trilinear_grid_interpolator dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// receiver: random stalls, plus a long hold-off whenever the sender asks for one
	always @(posedge clk) begin
		if (hold_reqs != hold_seen) begin
			hold_seen <= hold_reqs;
			hold_left <= HOLD_CYCLES;
			result_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= rx_pct);
		end
	end

	// result check: inputs only change at the rising edge, so the values seen at the
	// falling edge are the ones the next rising edge takes
	always @(negedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (pending_results.size() == 0) begin
				$error("result transaction with no expectation waiting: value %0d in_range %0b",
					result.interp_value, result.in_range);
				errors++;
			end else begin
				tgi_result_t want;
				want = pending_results.pop_front();
				if (result.interp_value !== want.interp_value) begin
					$error("interp_value: expected %0d, actual %0d",
						want.interp_value, result.interp_value);
					errors++;
				end
				if (result.in_range !== want.in_range) begin
					$error("in_range: expected %0b, actual %0b", want.in_range, result.in_range);
					errors++;
				end
			end
		end
	end

	// one axis: cell index and Q1.16 fraction, or out of range
	function automatic bit locate_axis(logic signed [31:0] coord, logic signed [31:0] org,
			logic [31:0] recip, output int cell_no, output longint frac);
		longint d;
		bit [63:0] p;
		bit [63:0] c;
		d = longint'(coord) - longint'(org);
		cell_no = 0;
		frac = 0;
		if (recip == 0 || d < 0) return 1'b0;
		p = 64'(d) * 64'(recip);
		if (p > (64'(CELLS) << 32)) return 1'b0;
		c = p >> 32;
		if (c > 64'(CELLS - 1)) c = 64'(CELLS - 1);
		cell_no = int'(c);
		frac = longint'((p >> 16) - (c << 16));
		return 1'b1;
	endfunction

	// base corner of the cell that holds the point, with the three fractions
	function automatic bit find_cell(tgi_item_t it, output int base, output longint tx,
			output longint ty, output longint tz);
		int cx, cy, cz;
		bit ok;
		ok = locate_axis(it.coord_x, origin_r[0], recip_r[0], cx, tx);
		ok &= locate_axis(it.coord_y, origin_r[1], recip_r[1], cy, ty);
		ok &= locate_axis(it.coord_z, origin_r[2], recip_r[2], cz, tz);
		base = cx + ROW_PTS * cy + PLANE_PTS * cz;
		return ok;
	endfunction

	// a*(1-t) + b*t with round half up, saturated to 32 bits
	function automatic longint blend(longint a, longint b, longint t);
		longint r;
		r = (a * (65536 - t) + b * t + 32768) >>> 16;
		if (r > 64'sd2147483647) r = 64'sd2147483647;
		if (r < -64'sd2147483648) r = -64'sd2147483648;
		return r;
	endfunction

	function automatic longint sample(int idx);
		return longint'(grid_mem[idx % GRID_PTS]);
	endfunction

	function automatic tgi_result_t interpolate(tgi_item_t it);
		tgi_result_t r;
		int b;
		longint tx, ty, tz, c00, c10, c01, c11;
		r = '0;
		if (!find_cell(it, b, tx, ty, tz)) return r;
		c00 = blend(sample(b), sample(b + 1), tx);
		c10 = blend(sample(b + ROW_PTS), sample(b + ROW_PTS + 1), tx);
		c01 = blend(sample(b + PLANE_PTS), sample(b + PLANE_PTS + 1), tx);
		c11 = blend(sample(b + PLANE_PTS + ROW_PTS), sample(b + PLANE_PTS + ROW_PTS + 1), tx);
		r.interp_value = 32'(blend(blend(c00, c10, ty), blend(c01, c11, ty), tz));
		r.in_range = 1'b1;
		return r;
	endfunction

	// offer one item, with random sender gaps; prediction happens as it is taken
	task automatic send_item(tgi_item_t it, bit typed = 1'b0, tgi_result_t res = '0);
		bit taken;
		while ($urandom_range(99) < tx_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do begin
			@(negedge clk);
			taken = item_ready;
			if (taken) begin
				items_sent++;
				if (it.func == FUNC_WRITE) begin
					grid_mem[it.point_index] = it.point_value;
					written[it.point_index] = 1'b1;
				end else begin
					pending_results.push_back(typed ? res : interpolate(it));
				end
			end
			@(posedge clk);
		end while (!taken);
	endtask

	function automatic logic [31:0] rand_value();
		case ($urandom_range(7))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'($urandom_range(131072)) - 32'd65536;
			default: return $urandom;
		endcase
	endfunction

	// a lookup first writes any corner of its cell that holds no sample yet
	task automatic send_lookup(tgi_item_t it, bit typed = 1'b0, tgi_result_t res = '0);
		int b, idx;
		longint tx, ty, tz;
		tgi_item_t wr;
		int offs [8] = '{0, 1, ROW_PTS, ROW_PTS + 1, PLANE_PTS, PLANE_PTS + 1,
			PLANE_PTS + ROW_PTS, PLANE_PTS + ROW_PTS + 1};
		if (find_cell(it, b, tx, ty, tz)) begin
			foreach (offs[n]) begin
				idx = (b + offs[n]) % GRID_PTS;
				if (!written[idx]) begin
					wr = ITEM_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
					wr.func = FUNC_WRITE;
					wr.point_index = GRID_AW'(idx);
					wr.point_value = rand_value();
					send_item(wr);
				end
			end
		end
		send_item(it, typed, res);
	endtask

	// wait until every result is in, then let trailing writes leave the pipeline
	task automatic drain();
		item_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] index, logic [31:0] data);
		bit taken;
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		do begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end while (!taken);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (index)
			CFG_ORIGIN_X: origin_r[0] = data;
			CFG_ORIGIN_Y: origin_r[1] = data;
			CFG_ORIGIN_Z: origin_r[2] = data;
			CFG_RECIP_X: recip_r[0] = data;
			CFG_RECIP_Y: recip_r[1] = data;
			CFG_RECIP_Z: recip_r[2] = data;
			default: ;
		endcase
	endtask

	// coordinate on one axis, mostly in or near the grid span
	function automatic logic [31:0] pick_coord(int a);
		longint span, off, c, rnd;
		if (recip_r[a] == 0 || $urandom_range(99) < 15) return $urandom;
		span = longint'((64'(CELLS) << 32) / 64'(recip_r[a]));
		if ($urandom_range(99) < 5) begin
			off = span;
		end else begin
			rnd = longint'({$urandom, $urandom} >> 1);
			off = rnd % (span + span / 8 + 2) - span / 16 - 1;
		end
		c = longint'(origin_r[a]) + off;
		if (c > 64'sd2147483647) c = 64'sd2147483647;
		if (c < -64'sd2147483648) c = -64'sd2147483648;
		return 32'(c);
	endfunction

	function automatic tgi_item_t make_lookup(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		tgi_item_t it;
		it = ITEM_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
		it.func = FUNC_LOOKUP;
		it.coord_x = x;
		it.coord_y = y;
		it.coord_z = z;
		return it;
	endfunction

	function automatic stim_row_t item_row(tgi_item_t it, bit typed = 1'b0);
		stim_row_t r;
		r.kind = ROW_ITEM;
		r.item = it;
		r.index = CFG_ORIGIN_X;
		r.data = '0;
		r.typed = typed;
		r.res = '0;
		return r;
	endfunction

	function automatic stim_row_t cfg_row(logic [2:0] index, logic [31:0] data);
		stim_row_t r;
		r = item_row('0);
		r.kind = ROW_CFG;
		r.index = index;
		r.data = data;
		return r;
	endfunction

	function automatic stim_row_t write_row(int idx, logic [31:0] val);
		tgi_item_t it;
		it = '0;
		it.func = FUNC_WRITE;
		it.point_index = GRID_AW'(idx);
		it.point_value = val;
		return item_row(it);
	endfunction

	function automatic stim_row_t make_row_lookup(logic [31:0] x, logic [31:0] y,
			logic [31:0] z, bit outside);
		// out-of-range rows carry their result typed in: zero with in_range low
		return item_row(make_lookup(x, y, z), outside);
	endfunction

	task automatic run_phase(int mode, bit pressure);
		tgi_item_t it;
		int stop;
		case (mode)
			0: begin tx_pct = 0; rx_pct = 0; end
			1: begin tx_pct = 63; rx_pct = 0; end
			2: begin tx_pct = 0; rx_pct = 63; end
			default: begin tx_pct = 28; rx_pct = 28; end
		endcase
		if (pressure) hold_reqs++;
		stop = items_sent + ITEMS_PER_PHASE;
		while (items_sent < stop) begin
			if ($urandom_range(99) < 15) begin
				// write noise at any index
				it = ITEM_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
				it.func = FUNC_WRITE;
				it.point_value = rand_value();
				send_item(it);
			end else begin
				send_lookup(make_lookup(pick_coord(0), pick_coord(1), pick_coord(2)));
			end
		end
		drain();
	endtask

	task automatic set_all(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
			logic [31:0] rx, logic [31:0] ry, logic [31:0] rz);
		write_reg(CFG_ORIGIN_X, ox);
		write_reg(CFG_ORIGIN_Y, oy);
		write_reg(CFG_ORIGIN_Z, oz);
		write_reg(CFG_RECIP_X, rx);
		write_reg(CFG_RECIP_Y, ry);
		write_reg(CFG_RECIP_Z, rz);
	endtask

	function automatic logic [31:0] rand_recip();
		return 32'($urandom_range(32'h0010_0000, 32'h0000_4000));
	endfunction

	initial begin
		item_valid <= 1'b0;
		item <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_ORIGIN_X;
		cfg_data <= '0;
		result_ready <= 1'b0;
		for (int a = 0; a < 3; a++) begin
			origin_r[a] = '0;
			recip_r[a] = RECIP_RESET;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part under the reset settings
		rows.push_back(make_row_lookup(0, 0, 0, 1'b0));
		rows.push_back(write_row(0, 32'h7fff_ffff));
		rows.push_back(write_row(1, 32'h8000_0000));
		rows.push_back(write_row(GRID_PTS - 1, 32'h8000_0000));
		rows.push_back(make_row_lookup(32'h0000_8000, 0, 0, 1'b0));
		rows.push_back(make_row_lookup(32'h0001_8000, 32'h0002_4000, 32'h0003_c000, 1'b0));
		// top face of every axis: last cell, full fraction
		rows.push_back(make_row_lookup(32'h001f_0000, 32'h001f_0000, 32'h001f_0000, 1'b0));
		// below the origin and beyond the top give zero, out of range
		rows.push_back(make_row_lookup(32'hffff_ffff, 0, 0, 1'b1));
		rows.push_back(make_row_lookup(0, 32'h001f_0001, 0, 1'b1));
		rows.push_back(make_row_lookup(0, 0, 32'h7fff_ffff, 1'b1));
		rows.push_back(make_row_lookup(32'h8000_0000, 0, 0, 1'b1));
		// zero reciprocal step
		rows.push_back(cfg_row(CFG_RECIP_Z, 32'h0));
		rows.push_back(make_row_lookup(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b1));
		rows.push_back(cfg_row(CFG_RECIP_Z, RECIP_RESET));
		rows.push_back(make_row_lookup(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b0));

		foreach (rows[n]) begin
			if (rows[n].kind == ROW_CFG) begin
				drain();
				write_reg(rows[n].index, rows[n].data);
			end else if (rows[n].item.func == FUNC_LOOKUP) begin
				send_lookup(rows[n].item, rows[n].typed, rows[n].res);
			end else begin
				send_item(rows[n].item);
			end
		end
		drain();

		// random part over several settings, extremes among them
		run_phase(0, 1'b0);
		set_all($urandom, $urandom, $urandom, rand_recip(), rand_recip(), rand_recip());
		run_phase(1, 1'b0);
		set_all(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0000_0001, 32'hffff_ffff,
			RECIP_RESET);
		run_phase(2, 1'b0);
		set_all(32'h7fff_ffff, 32'($urandom_range(65536)), 32'h8000_0000, rand_recip(),
			32'hffff_ffff, 32'h0000_0001);
		run_phase(3, 1'b0);
		set_all($urandom, $urandom, $urandom, rand_recip(), 32'h0, rand_recip());
		run_phase(1, 1'b0);
		set_all(32'($urandom_range(65536)) - 32'd32768, 32'h0, $urandom, rand_recip(),
			RECIP_RESET, rand_recip());
		// the long receiver hold-off backs the block up against the sender
		run_phase(0, 1'b1);

		if (pending_results.size() != 0) errors++;
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
